// ----- design/tksd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types, key codes and decode tables for the terminal key sequence
// decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

	typedef logic [5:0] key_code_t;
	typedef logic [7:0] byte_t;
	typedef logic [15:0] tick_t;
	typedef logic [1:0] cfg_index_t;

	// Configuration register indexes
	localparam cfg_index_t CFG_PC_SCAN_MODE = 2'd0;
	localparam cfg_index_t CFG_IDLE_LIMIT   = 2'd1;
	localparam cfg_index_t CFG_GAP_LIMIT    = 2'd2;

	localparam tick_t IDLE_LIMIT_RST = 16'd1000;
	localparam tick_t GAP_LIMIT_RST  = 16'd100;
	localparam tick_t TICK_MAX       = 16'hFFFF;

	// Special bytes
	localparam byte_t B_NUL   = 8'd0;
	localparam byte_t B_BS    = 8'd8;
	localparam byte_t B_LF    = 8'd10;
	localparam byte_t B_CR    = 8'd13;
	localparam byte_t B_ESC   = 8'd27;
	localparam byte_t B_DEL   = 8'd127;
	localparam byte_t B_PCEXT = 8'd224;
	localparam byte_t B_LBRK  = 8'h5B; // '['
	localparam byte_t B_SS3   = 8'h4F; // 'O'
	localparam byte_t B_TILDE = 8'h7E; // '~'
	localparam byte_t B_SEMI  = 8'h3B; // ';'
	localparam byte_t B_DIG0  = 8'h30;
	localparam byte_t B_DIG9  = 8'h39;

	// Key codes
	localparam key_code_t K_CHAR    = 6'd0;
	localparam key_code_t K_ENTER   = 6'd1;
	localparam key_code_t K_BS      = 6'd2;
	localparam key_code_t K_ESC     = 6'd3;
	localparam key_code_t K_TIMEOUT = 6'd4;
	localparam key_code_t K_UP      = 6'd5;
	localparam key_code_t K_DOWN    = 6'd6;
	localparam key_code_t K_LEFT    = 6'd7;
	localparam key_code_t K_RIGHT   = 6'd8;
	localparam key_code_t K_HOME    = 6'd9;
	localparam key_code_t K_END     = 6'd10;
	localparam key_code_t K_PGUP    = 6'd11;
	localparam key_code_t K_PGDN    = 6'd12;
	localparam key_code_t K_INS     = 6'd13;
	localparam key_code_t K_DEL     = 6'd14;
	localparam key_code_t K_CHOME   = 6'd15;
	localparam key_code_t K_CEND    = 6'd16;
	localparam key_code_t K_F1      = 6'd17;
	localparam key_code_t K_F2      = 6'd18;
	localparam key_code_t K_F3      = 6'd19;
	localparam key_code_t K_F4      = 6'd20;
	localparam key_code_t K_F5      = 6'd21;
	localparam key_code_t K_F8      = 6'd22;
	localparam key_code_t K_F9      = 6'd23;
	localparam key_code_t K_F10     = 6'd24;
	localparam key_code_t K_ALTF    = 6'd25;
	localparam key_code_t K_ALTE    = 6'd26;
	localparam key_code_t K_ALTS    = 6'd27;
	localparam key_code_t K_ALTD    = 6'd28;
	localparam key_code_t K_ALTR    = 6'd29;
	localparam key_code_t K_ALTH    = 6'd30;
	localparam key_code_t K_SUP     = 6'd31;
	localparam key_code_t K_SDOWN   = 6'd32;
	localparam key_code_t K_SRIGHT  = 6'd33;
	localparam key_code_t K_SLEFT   = 6'd34;
	localparam key_code_t K_CINS    = 6'd35;
	localparam key_code_t K_SDEL    = 6'd36;
	localparam key_code_t K_SINS    = 6'd37;

	// Parser phase, one-hot
	typedef enum logic [8:0] {
		PH_IDLE     = 9'b000000001,
		PH_ESC      = 9'b000000010,
		PH_CSI      = 9'b000000100,
		PH_CSI_DIG  = 9'b000001000,
		PH_CSI_SEMI = 9'b000010000,
		PH_CSI_MOD  = 9'b000100000,
		PH_CSI_TWO  = 9'b001000000,
		PH_SS3      = 9'b010000000,
		PH_PC       = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic  pc_scan_mode;
		tick_t idle_limit;
		tick_t gap_limit;
	} cfg_t;

	typedef struct packed {
		logic      has_result;
		key_code_t key_code;
		byte_t     char_value;
	} step_res_t;

	// Cursor keys shared by CSI and SS3
	function automatic key_code_t cursor_key(input byte_t b);
		key_code_t k;
		case (b)
			8'h41:   k = K_UP;    // A
			8'h42:   k = K_DOWN;  // B
			8'h43:   k = K_RIGHT; // C
			8'h44:   k = K_LEFT;  // D
			8'h48:   k = K_HOME;  // H
			8'h46:   k = K_END;   // F
			default: k = K_ESC;
		endcase
		return k;
	endfunction

	// Alt+letter, either case
	function automatic key_code_t alt_key(input byte_t b);
		byte_t     lc;
		key_code_t k;
		lc = b | 8'h20;
		case (lc)
			8'h66:   k = K_ALTF; // f
			8'h65:   k = K_ALTE; // e
			8'h73:   k = K_ALTS; // s
			8'h64:   k = K_ALTD; // d
			8'h72:   k = K_ALTR; // r
			8'h68:   k = K_ALTH; // h
			default: k = K_ESC;
		endcase
		return k;
	endfunction

	// PC console scan codes
	function automatic key_code_t pc_key(input byte_t b);
		key_code_t k;
		case (b)
			8'd72:   k = K_UP;
			8'd80:   k = K_DOWN;
			8'd75:   k = K_LEFT;
			8'd77:   k = K_RIGHT;
			8'd71:   k = K_HOME;
			8'd79:   k = K_END;
			8'd73:   k = K_PGUP;
			8'd81:   k = K_PGDN;
			8'd82:   k = K_INS;
			8'd83:   k = K_DEL;
			8'd119:  k = K_CHOME;
			8'd117:  k = K_CEND;
			8'd59:   k = K_F1;
			8'd60:   k = K_F2;
			8'd61:   k = K_F3;
			8'd62:   k = K_F4;
			8'd63:   k = K_F5;
			8'd66:   k = K_F8;
			8'd67:   k = K_F9;
			8'd68:   k = K_F10;
			8'd33:   k = K_ALTF;
			8'd18:   k = K_ALTE;
			8'd31:   k = K_ALTS;
			8'd32:   k = K_ALTD;
			8'd19:   k = K_ALTR;
			8'd35:   k = K_ALTH;
			8'd152:  k = K_SUP;
			8'd160:  k = K_SDOWN;
			8'd164:  k = K_CINS;
			8'd165:  k = K_SDEL;
			8'd166:  k = K_SINS;
			default: k = K_ESC;
		endcase
		return k;
	endfunction

	// SS3 final byte: F-keys, else cursor keys
	function automatic key_code_t ss3_key(input byte_t b);
		key_code_t k;
		case (b)
			8'h50:   k = K_F1; // P
			8'h51:   k = K_F2; // Q
			8'h52:   k = K_F3; // R
			8'h53:   k = K_F4; // S
			8'h74:   k = K_F5; // t
			8'h77:   k = K_F8; // w
			8'h78:   k = K_F9; // x
			default: k = cursor_key(b);
		endcase
		return k;
	endfunction

	// ESC [ d ~ editing keys
	function automatic key_code_t csi_tilde_key(input byte_t d);
		key_code_t k;
		case (d)
			8'h31, 8'h37: k = K_HOME;
			8'h32:        k = K_INS;
			8'h33:        k = K_DEL;
			8'h34, 8'h38: k = K_END;
			8'h35:        k = K_PGUP;
			8'h36:        k = K_PGDN;
			default:      k = K_ESC;
		endcase
		return k;
	endfunction

	// ESC [ d ; m f modified keys
	function automatic key_code_t csi_mod_key(input byte_t d, input byte_t m,
			input byte_t f);
		key_code_t k;
		k = K_ESC;
		if (d == 8'h31 && m == 8'h32) begin
			case (f)
				8'h41:   k = K_SUP;
				8'h42:   k = K_SDOWN;
				8'h43:   k = K_SRIGHT;
				8'h44:   k = K_SLEFT;
				default: k = K_ESC;
			endcase
		end else if (d == 8'h31 && m == 8'h35) begin
			case (f)
				8'h48:   k = K_CHOME;
				8'h46:   k = K_CEND;
				default: k = K_ESC;
			endcase
		end else if (f == B_TILDE) begin
			if (d == 8'h32 && m == 8'h35)      k = K_CINS;
			else if (d == 8'h33 && m == 8'h32) k = K_SDEL;
			else if (d == 8'h32 && m == 8'h32) k = K_SINS;
		end
		return k;
	endfunction

	// ESC [ d1 d2 ~ function keys
	function automatic key_code_t csi_two_key(input byte_t d1, input byte_t d2,
			input byte_t f);
		key_code_t k;
		k = K_ESC;
		if (f == B_TILDE) begin
			if (d1 == 8'h31) begin
				case (d2)
					8'h31:   k = K_F1;
					8'h32:   k = K_F2;
					8'h33:   k = K_F3;
					8'h34:   k = K_F4;
					8'h35:   k = K_F5;
					8'h39:   k = K_F8;
					default: k = K_ESC;
				endcase
			end else if (d1 == 8'h32) begin
				case (d2)
					8'h30:   k = K_F9;
					8'h31:   k = K_F10;
					default: k = K_ESC;
				endcase
			end
		end
		return k;
	endfunction

endpackage
`default_nettype wire

// ----- design/tksd_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_in_if
// Request channel into the decoder: one byte or one timer tick per request.
// ----------------------------------------------------------------------------
interface tksd_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, output cmd, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- design/tksd_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_out_if
// Key channel out of the decoder: one key code and its character per request.
// ----------------------------------------------------------------------------
interface tksd_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] key_code;
	logic [7:0] char_value;

	modport source (output valid, output key_code, output char_value, input ready);
	modport sink   (input valid, input key_code, input char_value, output ready);
endinterface
`default_nettype wire

// ----- design/tksd_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_cfg_regs
// Configuration register file: mode, idle timeout and in-sequence gap limit.
// ----------------------------------------------------------------------------
module tksd_cfg_regs (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire tksd_pkg::cfg_index_t cfg_index,
	input  wire logic [15:0]         cfg_wdata,
	output tksd_pkg::cfg_t           cfg
);

	logic             pc_scan_mode_q;
	tksd_pkg::tick_t  idle_limit_q;
	tksd_pkg::tick_t  gap_limit_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_scan_mode_q <= 1'b0;
			idle_limit_q   <= tksd_pkg::IDLE_LIMIT_RST;
			gap_limit_q    <= tksd_pkg::GAP_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tksd_pkg::CFG_PC_SCAN_MODE: pc_scan_mode_q <= cfg_wdata[0];
				tksd_pkg::CFG_IDLE_LIMIT:   idle_limit_q   <= cfg_wdata;
				tksd_pkg::CFG_GAP_LIMIT:    gap_limit_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg.pc_scan_mode = pc_scan_mode_q;
	assign cfg.idle_limit   = idle_limit_q;
	assign cfg.gap_limit    = gap_limit_q;

endmodule
`default_nettype wire

// ----- design/tksd_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_parser
// Sequence parser: phase register, saved sequence bytes, tick counter and the
// combinational decode of one request into at most one key.
// ----------------------------------------------------------------------------
module tksd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             cmd,
	input  wire tksd_pkg::byte_t  rx_byte,
	input  wire tksd_pkg::cfg_t   cfg,
	output tksd_pkg::step_res_t   res
);

	tksd_pkg::phase_t phase_q, phase_d;
	tksd_pkg::byte_t  second_byte_q, second_byte_d;
	tksd_pkg::byte_t  third_byte_q, third_byte_d;
	tksd_pkg::byte_t  fourth_byte_q, fourth_byte_d;
	tksd_pkg::tick_t  tick_q, tick_d;
	tksd_pkg::tick_t  tick_sat;
	logic             go_idle;

	// Saturating idle count
	assign tick_sat = (tick_q < tksd_pkg::TICK_MAX) ? tick_q + 16'd1 : tick_q;

	// Next state and result
	always_comb begin
		phase_d       = phase_q;
		second_byte_d = second_byte_q;
		third_byte_d  = third_byte_q;
		fourth_byte_d = fourth_byte_q;
		tick_d        = tick_q;
		go_idle       = 1'b0;
		res           = '0;

		if (cmd) begin
			// timer tick
			if (phase_q == tksd_pkg::PH_IDLE) begin
				if (tick_sat >= cfg.idle_limit) begin
					tick_d         = '0;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::K_TIMEOUT;
				end else begin
					tick_d = tick_sat;
				end
			end else if (phase_q != tksd_pkg::PH_PC) begin
				if (tick_q >= cfg.gap_limit) begin
					tick_d         = '0;
					go_idle        = 1'b1;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::K_ESC;
				end else begin
					tick_d = tick_q + 16'd1;
				end
			end
		end else begin
			// received byte
			tick_d = '0;
			case (phase_q)
				tksd_pkg::PH_IDLE: begin
					if (rx_byte == tksd_pkg::B_CR || rx_byte == tksd_pkg::B_LF) begin
						res.has_result = 1'b1;
						res.key_code   = tksd_pkg::K_ENTER;
					end else if (rx_byte == tksd_pkg::B_BS || rx_byte == tksd_pkg::B_DEL) begin
						res.has_result = 1'b1;
						res.key_code   = tksd_pkg::K_BS;
					end else if (cfg.pc_scan_mode &&
							(rx_byte == tksd_pkg::B_NUL || rx_byte == tksd_pkg::B_PCEXT)) begin
						phase_d = tksd_pkg::PH_PC;
					end else if (!cfg.pc_scan_mode && rx_byte == tksd_pkg::B_ESC) begin
						phase_d = tksd_pkg::PH_ESC;
					end else begin
						res.has_result = 1'b1;
						res.key_code   = tksd_pkg::K_CHAR;
						res.char_value = rx_byte;
					end
				end
				tksd_pkg::PH_PC: begin
					go_idle        = 1'b1;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::pc_key(rx_byte);
				end
				tksd_pkg::PH_ESC: begin
					if (rx_byte == tksd_pkg::B_LBRK) begin
						phase_d = tksd_pkg::PH_CSI;
					end else if (rx_byte == tksd_pkg::B_SS3) begin
						phase_d = tksd_pkg::PH_SS3;
					end else begin
						go_idle        = 1'b1;
						res.has_result = 1'b1;
						res.key_code   = tksd_pkg::alt_key(rx_byte);
					end
				end
				tksd_pkg::PH_SS3: begin
					go_idle        = 1'b1;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::ss3_key(rx_byte);
				end
				tksd_pkg::PH_CSI: begin
					if (rx_byte >= tksd_pkg::B_DIG0 && rx_byte <= tksd_pkg::B_DIG9) begin
						second_byte_d = rx_byte;
						phase_d       = tksd_pkg::PH_CSI_DIG;
					end else begin
						go_idle        = 1'b1;
						res.has_result = 1'b1;
						res.key_code   = tksd_pkg::cursor_key(rx_byte);
					end
				end
				tksd_pkg::PH_CSI_DIG: begin
					third_byte_d = rx_byte;
					if (rx_byte == tksd_pkg::B_TILDE) begin
						go_idle        = 1'b1;
						res.has_result = 1'b1;
						res.key_code   = tksd_pkg::csi_tilde_key(second_byte_q);
					end else if (rx_byte == tksd_pkg::B_SEMI) begin
						phase_d = tksd_pkg::PH_CSI_SEMI;
					end else begin
						phase_d = tksd_pkg::PH_CSI_TWO;
					end
				end
				tksd_pkg::PH_CSI_SEMI: begin
					fourth_byte_d = rx_byte;
					phase_d       = tksd_pkg::PH_CSI_MOD;
				end
				tksd_pkg::PH_CSI_MOD: begin
					go_idle        = 1'b1;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::csi_mod_key(second_byte_q, fourth_byte_q,
						rx_byte);
				end
				tksd_pkg::PH_CSI_TWO: begin
					go_idle        = 1'b1;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::csi_two_key(second_byte_q, third_byte_q,
						rx_byte);
				end
				default: begin
					go_idle        = 1'b1;
					res.has_result = 1'b1;
					res.key_code   = tksd_pkg::K_ESC;
				end
			endcase
		end

		// sequence ended or dropped
		if (go_idle) begin
			phase_d       = tksd_pkg::PH_IDLE;
			second_byte_d = '0;
			third_byte_d  = '0;
			fourth_byte_d = '0;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tksd_pkg::PH_IDLE;
			second_byte_q <= '0;
			third_byte_q  <= '0;
			fourth_byte_q <= '0;
			tick_q        <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			second_byte_q <= second_byte_d;
			third_byte_q  <= third_byte_d;
			fourth_byte_q <= fourth_byte_d;
			tick_q        <= tick_d;
		end
	end

endmodule
`default_nettype wire

// ----- design/terminal_key_sequence_decoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder_core
// Turns keyboard bytes and timer ticks into key codes (ANSI or PC scan mode).
// ----------------------------------------------------------------------------
// Usage:
//   rx_ch carries one request per accepted valid/ready beat: cmd 0 with a
//   received byte, or cmd 1 for one elapsed timer tick. key_ch delivers key
//   requests (key_code, char_value); a request on rx_ch yields zero or one
//   key request.
//   A request accepted on rx_ch sits in the input register, is decoded
//   combinationally and its key is loaded into the output register for key_ch.
//   One request per cycle is taken while key_ch does not stall; the decode
//   between the input register and the output register is combinational.
//   If key_ch stalls with a key pending, the output register holds it; the
//   input register still takes one more request, then rx_ch.ready drops until
//   the key is taken. A held request waits on a pending key even when it
//   yields no key itself.
//   Configuration (cfg_we, cfg_wdata; cfg_index 0 pc_scan_mode, 1 idle_limit,
//   2 gap_limit) is the user's to write while the block is idle; not enforced.
//   Reset clears both registers' valid flags and puts the parser idle with
//   tick count zero; registers reset to ANSI mode, idle 1000, gap 100.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tksd_in_if.sink          rx_ch,
	tksd_out_if.source       key_ch,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	tksd_pkg::cfg_t      cfg;
	tksd_pkg::step_res_t res;

	logic                item_valid_s1;
	logic                cmd_s1;
	tksd_pkg::byte_t     rx_byte_s1;
	logic                out_valid_q;
	tksd_pkg::key_code_t key_code_q;
	tksd_pkg::byte_t     char_value_q;
	logic                step;

	// Decode the held request when the output slot is free or being drained
	assign step        = item_valid_s1 && (!out_valid_q || key_ch.ready);
	assign rx_ch.ready = !item_valid_s1 || step;

	tksd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tksd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.cmd     (cmd_s1),
		.rx_byte (rx_byte_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (rx_ch.ready) begin
			item_valid_s1 <= rx_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ch.valid && rx_ch.ready) begin
			cmd_s1     <= rx_ch.cmd;
			rx_byte_s1 <= rx_ch.rx_byte;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res.has_result;
		end else if (key_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.has_result) begin
			key_code_q   <= res.key_code;
			char_value_q <= res.char_value;
		end
	end

	assign key_ch.valid      = out_valid_q;
	assign key_ch.key_code   = key_code_q;
	assign key_ch.char_value = char_value_q;

endmodule
`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the terminal key sequence decoder. A short table of
// byte and tick requests covers pass-through bytes, Alt, CSI, SS3 and function
// keys. Random well-formed ANSI and PC prefix sequences follow, mixed with
// noise, stray ticks and broken sequences, over several register settings and
// both-sided flow control. An in-bench decoder predicts keys the table omits.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int                   PIPE_LAT     = 4;
	localparam int                   DRAIN_CYCLES = 2000;
	localparam int                   RUN_LIMIT_NS = 1_000_000;
	localparam tksd_pkg::cfg_index_t CFG_UNUSED   = 2'd3;

	// Scan codes that the PC table knows
	localparam tksd_pkg::byte_t SCAN_SET [31] = '{72, 80, 75, 77, 71, 79, 73, 81, 82, 83,
		119, 117, 59, 60, 61, 62, 63, 66, 67, 68, 33, 18, 31, 32, 19, 35, 152, 160, 164,
		165, 166};

	typedef enum logic [1:0] {ROW_MODEL, ROW_KEY, ROW_QUIET} row_kind_t;

	typedef struct packed {
		logic                tick;
		tksd_pkg::byte_t     data;
		row_kind_t           kind;
		tksd_pkg::key_code_t code;
		tksd_pkg::byte_t     ch;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	tksd_pkg::cfg_index_t cfg_index;
	logic [15:0]          cfg_wdata;

	tksd_in_if  rx_link ();
	tksd_out_if key_link ();

	terminal_key_sequence_decoder_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_ch     (rx_link),
		.key_ch    (key_link),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Decoder shadow: registers and parser state
	logic             dec_pc_mode    = 1'b0;
	tksd_pkg::tick_t  dec_idle_limit = tksd_pkg::IDLE_LIMIT_RST;
	tksd_pkg::tick_t  dec_gap_limit  = tksd_pkg::GAP_LIMIT_RST;
	tksd_pkg::phase_t dec_phase      = tksd_pkg::PH_IDLE;
	tksd_pkg::byte_t  dec_lead       = '0;
	tksd_pkg::byte_t  dec_mid        = '0;
	tksd_pkg::byte_t  dec_mod        = '0;
	tksd_pkg::tick_t  dec_ticks      = '0;

	tksd_pkg::step_res_t keys_due [$];
	int                  mismatches    = 0;
	int                  items_sent    = 0;
	int                  send_idle_pct = 36;
	int                  recv_idle_pct = 77;

	// Directed requests, ANSI mode with reset limits
	stim_row_t directed_rows [26] = '{
		'{1'b0, 8'h61,             ROW_KEY,   tksd_pkg::K_CHAR,  8'h61},
		'{1'b0, 8'h00,             ROW_KEY,   tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, 8'hFF,             ROW_KEY,   tksd_pkg::K_CHAR,  8'hFF},
		'{1'b0, tksd_pkg::B_CR,    ROW_KEY,   tksd_pkg::K_ENTER, 8'h00},
		'{1'b0, tksd_pkg::B_LF,    ROW_KEY,   tksd_pkg::K_ENTER, 8'h00},
		'{1'b0, tksd_pkg::B_BS,    ROW_KEY,   tksd_pkg::K_BS,    8'h00},
		'{1'b0, tksd_pkg::B_DEL,   ROW_KEY,   tksd_pkg::K_BS,    8'h00},
		'{1'b1, 8'h5A,             ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_ESC,   ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "F",               ROW_MODEL, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_ESC,   ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_ESC,   ROW_KEY,   tksd_pkg::K_ESC,   8'h00},
		'{1'b0, tksd_pkg::B_ESC,   ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_LBRK,  ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "2",               ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "1",               ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_TILDE, ROW_MODEL, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_ESC,   ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_LBRK,  ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "1",               ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_SEMI,  ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "5",               ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "H",               ROW_MODEL, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_ESC,   ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, tksd_pkg::B_SS3,   ROW_QUIET, tksd_pkg::K_CHAR,  8'h00},
		'{1'b0, "x",               ROW_MODEL, tksd_pkg::K_CHAR,  8'h00}
	};

	initial begin : clock_gen
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Key lookups
	// ------------------------------------------------------------------
	function automatic tksd_pkg::key_code_t arrow_key(input tksd_pkg::byte_t b);
		case (b)
			"A":     return tksd_pkg::K_UP;
			"B":     return tksd_pkg::K_DOWN;
			"C":     return tksd_pkg::K_RIGHT;
			"D":     return tksd_pkg::K_LEFT;
			"H":     return tksd_pkg::K_HOME;
			"F":     return tksd_pkg::K_END;
			default: return tksd_pkg::K_ESC;
		endcase
	endfunction

	function automatic tksd_pkg::key_code_t alt_letter_key(input tksd_pkg::byte_t b);
		case (b | 8'h20)
			"f":     return tksd_pkg::K_ALTF;
			"e":     return tksd_pkg::K_ALTE;
			"s":     return tksd_pkg::K_ALTS;
			"d":     return tksd_pkg::K_ALTD;
			"r":     return tksd_pkg::K_ALTR;
			"h":     return tksd_pkg::K_ALTH;
			default: return tksd_pkg::K_ESC;
		endcase
	endfunction

	function automatic tksd_pkg::key_code_t scan_key(input tksd_pkg::byte_t b);
		case (b)
			72:      return tksd_pkg::K_UP;
			80:      return tksd_pkg::K_DOWN;
			75:      return tksd_pkg::K_LEFT;
			77:      return tksd_pkg::K_RIGHT;
			71:      return tksd_pkg::K_HOME;
			79:      return tksd_pkg::K_END;
			73:      return tksd_pkg::K_PGUP;
			81:      return tksd_pkg::K_PGDN;
			82:      return tksd_pkg::K_INS;
			83:      return tksd_pkg::K_DEL;
			119:     return tksd_pkg::K_CHOME;
			117:     return tksd_pkg::K_CEND;
			59:      return tksd_pkg::K_F1;
			60:      return tksd_pkg::K_F2;
			61:      return tksd_pkg::K_F3;
			62:      return tksd_pkg::K_F4;
			63:      return tksd_pkg::K_F5;
			66:      return tksd_pkg::K_F8;
			67:      return tksd_pkg::K_F9;
			68:      return tksd_pkg::K_F10;
			33:      return tksd_pkg::K_ALTF;
			18:      return tksd_pkg::K_ALTE;
			31:      return tksd_pkg::K_ALTS;
			32:      return tksd_pkg::K_ALTD;
			19:      return tksd_pkg::K_ALTR;
			35:      return tksd_pkg::K_ALTH;
			152:     return tksd_pkg::K_SUP;
			160:     return tksd_pkg::K_SDOWN;
			164:     return tksd_pkg::K_CINS;
			165:     return tksd_pkg::K_SDEL;
			166:     return tksd_pkg::K_SINS;
			default: return tksd_pkg::K_ESC;
		endcase
	endfunction

	function automatic tksd_pkg::key_code_t ss3_final_key(input tksd_pkg::byte_t b);
		case (b)
			"P":     return tksd_pkg::K_F1;
			"Q":     return tksd_pkg::K_F2;
			"R":     return tksd_pkg::K_F3;
			"S":     return tksd_pkg::K_F4;
			"t":     return tksd_pkg::K_F5;
			"w":     return tksd_pkg::K_F8;
			"x":     return tksd_pkg::K_F9;
			default: return arrow_key(b);
		endcase
	endfunction

	function automatic tksd_pkg::key_code_t edit_key(input tksd_pkg::byte_t d);
		case (d)
			"1", "7": return tksd_pkg::K_HOME;
			"2":      return tksd_pkg::K_INS;
			"3":      return tksd_pkg::K_DEL;
			"4", "8": return tksd_pkg::K_END;
			"5":      return tksd_pkg::K_PGUP;
			"6":      return tksd_pkg::K_PGDN;
			default:  return tksd_pkg::K_ESC;
		endcase
	endfunction

	// ESC [ d ; m f
	function automatic tksd_pkg::key_code_t modified_key(input tksd_pkg::byte_t d,
			input tksd_pkg::byte_t m, input tksd_pkg::byte_t f);
		case ({d, m, f})
			{"1", "2", "A"}: return tksd_pkg::K_SUP;
			{"1", "2", "B"}: return tksd_pkg::K_SDOWN;
			{"1", "2", "C"}: return tksd_pkg::K_SRIGHT;
			{"1", "2", "D"}: return tksd_pkg::K_SLEFT;
			{"1", "5", "H"}: return tksd_pkg::K_CHOME;
			{"1", "5", "F"}: return tksd_pkg::K_CEND;
			{"2", "5", "~"}: return tksd_pkg::K_CINS;
			{"3", "2", "~"}: return tksd_pkg::K_SDEL;
			{"2", "2", "~"}: return tksd_pkg::K_SINS;
			default:         return tksd_pkg::K_ESC;
		endcase
	endfunction

	// ESC [ d1 d2 f
	function automatic tksd_pkg::key_code_t fkey_key(input tksd_pkg::byte_t d1,
			input tksd_pkg::byte_t d2, input tksd_pkg::byte_t f);
		case ({d1, d2, f})
			{"1", "1", "~"}: return tksd_pkg::K_F1;
			{"1", "2", "~"}: return tksd_pkg::K_F2;
			{"1", "3", "~"}: return tksd_pkg::K_F3;
			{"1", "4", "~"}: return tksd_pkg::K_F4;
			{"1", "5", "~"}: return tksd_pkg::K_F5;
			{"1", "9", "~"}: return tksd_pkg::K_F8;
			{"2", "0", "~"}: return tksd_pkg::K_F9;
			{"2", "1", "~"}: return tksd_pkg::K_F10;
			default:         return tksd_pkg::K_ESC;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Decoder shadow: one request in, zero or one key out
	// ------------------------------------------------------------------
	function automatic tksd_pkg::step_res_t close_seq(input tksd_pkg::key_code_t code);
		dec_phase = tksd_pkg::PH_IDLE;
		dec_lead  = '0;
		dec_mid   = '0;
		dec_mod   = '0;
		return {1'b1, code, 8'h00};
	endfunction

	function automatic tksd_pkg::step_res_t decode_key(input logic tick,
			input tksd_pkg::byte_t b);
		tksd_pkg::step_res_t res;
		res = '0;
		if (tick) begin
			if (dec_phase == tksd_pkg::PH_IDLE) begin
				if (dec_ticks != tksd_pkg::TICK_MAX)
					dec_ticks = dec_ticks + 1'b1;
				if (dec_ticks >= dec_idle_limit) begin
					dec_ticks = '0;
					res = {1'b1, tksd_pkg::K_TIMEOUT, 8'h00};
				end
			end else if (dec_phase != tksd_pkg::PH_PC) begin
				// prefix wait in PC mode never times out
				if (dec_ticks >= dec_gap_limit) begin
					dec_ticks = '0;
					res = close_seq(tksd_pkg::K_ESC);
				end else begin
					dec_ticks = dec_ticks + 1'b1;
				end
			end
			return res;
		end
		dec_ticks = '0;
		case (dec_phase)
			tksd_pkg::PH_IDLE: begin
				if (b == tksd_pkg::B_CR || b == tksd_pkg::B_LF)
					res = {1'b1, tksd_pkg::K_ENTER, 8'h00};
				else if (b == tksd_pkg::B_BS || b == tksd_pkg::B_DEL)
					res = {1'b1, tksd_pkg::K_BS, 8'h00};
				else if (dec_pc_mode && (b == tksd_pkg::B_NUL || b == tksd_pkg::B_PCEXT))
					dec_phase = tksd_pkg::PH_PC;
				else if (!dec_pc_mode && b == tksd_pkg::B_ESC)
					dec_phase = tksd_pkg::PH_ESC;
				else
					res = {1'b1, tksd_pkg::K_CHAR, b};
			end
			tksd_pkg::PH_PC: res = close_seq(scan_key(b));
			tksd_pkg::PH_ESC: begin
				if (b == tksd_pkg::B_LBRK)
					dec_phase = tksd_pkg::PH_CSI;
				else if (b == tksd_pkg::B_SS3)
					dec_phase = tksd_pkg::PH_SS3;
				else
					res = close_seq(alt_letter_key(b));
			end
			tksd_pkg::PH_SS3: res = close_seq(ss3_final_key(b));
			tksd_pkg::PH_CSI: begin
				if (b >= tksd_pkg::B_DIG0 && b <= tksd_pkg::B_DIG9) begin
					dec_lead  = b;
					dec_phase = tksd_pkg::PH_CSI_DIG;
				end else begin
					res = close_seq(arrow_key(b));
				end
			end
			tksd_pkg::PH_CSI_DIG: begin
				dec_mid = b;
				if (b == tksd_pkg::B_TILDE)
					res = close_seq(edit_key(dec_lead));
				else if (b == tksd_pkg::B_SEMI)
					dec_phase = tksd_pkg::PH_CSI_SEMI;
				else
					dec_phase = tksd_pkg::PH_CSI_TWO;
			end
			tksd_pkg::PH_CSI_SEMI: begin
				dec_mod   = b;
				dec_phase = tksd_pkg::PH_CSI_MOD;
			end
			tksd_pkg::PH_CSI_MOD: res = close_seq(modified_key(dec_lead, dec_mod, b));
			tksd_pkg::PH_CSI_TWO: res = close_seq(fkey_key(dec_lead, dec_mid, b));
			default:              res = close_seq(tksd_pkg::K_ESC);
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic note_mismatch(input string what);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Key channel: compare each taken key, then pick next ready
	always @(posedge clk) begin : key_check
		tksd_pkg::step_res_t want;
		if (arst_n && key_link.valid && key_link.ready) begin
			if (keys_due.size() == 0) begin
				note_mismatch($sformatf("unexpected key %0d char %0d",
					key_link.key_code, key_link.char_value));
			end else begin
				want = keys_due.pop_front();
				if (key_link.key_code !== want.key_code)
					note_mismatch($sformatf("key_code %0d, expected %0d",
						key_link.key_code, want.key_code));
				if (key_link.char_value !== want.char_value)
					note_mismatch($sformatf("char_value %0d, expected %0d",
						key_link.char_value, want.char_value));
			end
		end
		key_link.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	// One request on rx_link; returns at the edge that takes it
	task automatic push_request(input logic tick, input tksd_pkg::byte_t data,
			input row_kind_t kind, input tksd_pkg::step_res_t typed);
		tksd_pkg::step_res_t got;
		logic                ignored;
		while ($urandom_range(99) < send_idle_pct) begin
			rx_link.valid <= 1'b0;
			@(posedge clk);
		end
		rx_link.valid   <= 1'b1;
		rx_link.cmd     <= tick;
		rx_link.rx_byte <= data;
		do @(posedge clk); while (!rx_link.ready);
		ignored = tick && (dec_phase == tksd_pkg::PH_PC);
		got = decode_key(tick, data);
		if (kind == ROW_MODEL) begin
			if (got.has_result)
				keys_due.push_back(got);
		end else if (kind == ROW_KEY) begin
			keys_due.push_back(typed);
		end
		if (!ignored)
			items_sent++;
	endtask

	// Hold off requests until every key is out and the pipe is empty
	task automatic wait_keys_drained();
		int waited;
		waited = 0;
		rx_link.valid <= 1'b0;
		while (keys_due.size() != 0 && waited < DRAIN_CYCLES) begin
			@(posedge clk);
			waited++;
		end
		if (keys_due.size() != 0) begin
			note_mismatch($sformatf("%0d expected keys never arrived", keys_due.size()));
			keys_due.delete();
		end
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic write_reg(input tksd_pkg::cfg_index_t idx, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			tksd_pkg::CFG_PC_SCAN_MODE: dec_pc_mode    = value[0];
			tksd_pkg::CFG_IDLE_LIMIT:   dec_idle_limit = value;
			tksd_pkg::CFG_GAP_LIMIT:    dec_gap_limit  = value;
			default: ; // no register behind this index
		endcase
	endtask

	// Often leaves a prefix pending, so the next byte decodes under the old mode
	task automatic set_config(input logic pc_mode, input tksd_pkg::tick_t idle_ticks,
			input tksd_pkg::tick_t gap_ticks);
		if ($urandom_range(1))
			push_request(1'b0, dec_pc_mode ? tksd_pkg::B_PCEXT : tksd_pkg::B_ESC,
				ROW_MODEL, '0);
		wait_keys_drained();
		write_reg(tksd_pkg::CFG_PC_SCAN_MODE, {15'($urandom), pc_mode});
		write_reg(tksd_pkg::CFG_IDLE_LIMIT, idle_ticks);
		write_reg(tksd_pkg::CFG_GAP_LIMIT, gap_ticks);
		write_reg(CFG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic tksd_pkg::byte_t any_of(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	// One burst: noise byte, ticks, or a sequence with stray ticks inside
	task automatic send_burst();
		tksd_pkg::byte_t seq [$];
		int              roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			seq.push_back(8'($urandom));
		end else if (roll < 27) begin
			repeat ($urandom_range(1, 8))
				push_request(1'b1, 8'($urandom), ROW_MODEL, '0);
		end else if (!dec_pc_mode) begin
			seq.push_back(tksd_pkg::B_ESC);
			if (roll >= 87) begin
				repeat ($urandom_range(1, 4))
					seq.push_back(8'($urandom));
			end else begin
				case ($urandom_range(5))
					0: seq.push_back(any_of("fesdrhFESDRHaz"));
					1: begin
						seq.push_back(tksd_pkg::B_LBRK);
						seq.push_back(any_of("ABCDHFEZ"));
					end
					2: begin
						seq.push_back(tksd_pkg::B_SS3);
						seq.push_back(any_of("PQRStwxABCDHFy"));
					end
					3: begin
						seq.push_back(tksd_pkg::B_LBRK);
						seq.push_back(any_of("0123456789"));
						seq.push_back(tksd_pkg::B_TILDE);
					end
					4: begin
						seq.push_back(tksd_pkg::B_LBRK);
						seq.push_back(any_of("12"));
						seq.push_back(any_of("0123459"));
						seq.push_back(any_of("~~~A"));
					end
					default: begin
						seq.push_back(tksd_pkg::B_LBRK);
						seq.push_back(any_of("123"));
						seq.push_back(tksd_pkg::B_SEMI);
						seq.push_back(any_of("25"));
						seq.push_back(any_of("ABCDHF~"));
					end
				endcase
			end
		end else begin
			seq.push_back($urandom_range(1) ? tksd_pkg::B_PCEXT : tksd_pkg::B_NUL);
			if (roll >= 87)
				seq.push_back(8'($urandom));
			else
				seq.push_back(SCAN_SET[$urandom_range(30)]);
		end
		foreach (seq[i]) begin
			if (i != 0 && $urandom_range(99) < 12)
				repeat ($urandom_range(1, 3))
					push_request(1'b1, 8'($urandom), ROW_MODEL, '0);
			push_request(1'b0, seq[i], ROW_MODEL, '0);
		end
	endtask

	task automatic run_random(input int target);
		int start;
		start = items_sent;
		while (items_sent - start < target)
			send_burst();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n           = 1'b0;
		rx_link.valid    = 1'b0;
		rx_link.cmd      = 1'b0;
		rx_link.rx_byte  = '0;
		key_link.ready   = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = tksd_pkg::CFG_PC_SCAN_MODE;
		cfg_wdata        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			push_request(directed_rows[i].tick, directed_rows[i].data, directed_rows[i].kind,
				{1'b1, directed_rows[i].code, directed_rows[i].ch});

		// ANSI, short idle timeout, short gap
		set_config(1'b0, 16'd3, 16'd1);
		run_random(130);

		// PC scan codes, timeout on every idle tick
		send_idle_pct = 77;
		recv_idle_pct = 36;
		set_config(1'b1, 16'd1, 16'd2);
		run_random(130);

		// Full rate from here on
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(1'b0, tksd_pkg::TICK_MAX, tksd_pkg::TICK_MAX);
		run_random(90);

		set_config(1'b1, 16'd6, 16'd3);
		run_random(80);

		wait_keys_drained();
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#(RUN_LIMIT_NS);
		$display("tb: failure");
		$finish;
	end

endmodule
